[sv/sha1_message_digest_macros.svh]
// ----------------------------------------------------------------------------
// SHA-1 message digest: assertion macros
// Shared property forms, clocked on clk and disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef SHA1_MESSAGE_DIGEST_MACROS_SVH
`define SHA1_MESSAGE_DIGEST_MACROS_SVH

// Same-cycle implication
`define SHA1_ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define SHA1_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sha1_md_pkg.sv]
// ----------------------------------------------------------------------------
// SHA-1 message digest package
// Constants, command and status types shared by controller and datapath.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package sha1_md_pkg;

  // Initial chaining value, word 0 in the lowest slot
  localparam logic [4:0][31:0] INIT_CHAIN = {
    32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
  };

  // Round constants, one per stage of twenty rounds
  localparam logic [3:0][31:0] ROUND_K = {
    32'hCA62C1D6, 32'h8F1BBCDC, 32'h6ED9EBA1, 32'h5A827999
  };

  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam logic [5:0] LENGTH_AT  = 6'd56;
  localparam logic [5:0] BLOCK_LAST = 6'd63;
  localparam logic [6:0] ROUND_LAST = 7'd79;
  localparam logic [2:0] WORD_LAST  = 3'd4;

  // Source of a byte shifted into the block buffer
  typedef enum logic [1:0] {
    SRC_DATA = 2'd0,
    SRC_MARK = 2'd1,
    SRC_ZERO = 2'd2,
    SRC_LEN  = 2'd3
  } src_t;

  // Controller to datapath
  typedef struct packed {
    logic ins_en;
    src_t ins_src;
    logic count_bits;
    logic load_vars;
    logic round_en;
    logic fold;
    logic emit;
    logic clear_msg;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fill_last;
    logic fill_at_len;
    logic round_last;
    logic out_busy;
  } status_t;

endpackage

`default_nettype wire

[sv/sha1_md_ctrl.sv]
// ----------------------------------------------------------------------------
// SHA-1 message digest controller
// Sequences byte intake, padding, the 80 compression rounds and digest hand-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_md_ctrl (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   in_valid,
  output logic                  in_ready,
  input  wire                   byte_present,
  input  wire                   end_of_message,
  input  sha1_md_pkg::status_t  status,
  output sha1_md_pkg::cmd_t     cmd
);

  typedef enum logic [7:0] {
    ST_IDLE   = 8'b0000_0001,
    ST_PAD80  = 8'b0000_0010,
    ST_PADZ   = 8'b0000_0100,
    ST_PADLEN = 8'b0000_1000,
    ST_LOAD   = 8'b0001_0000,
    ST_ROUND  = 8'b0010_0000,
    ST_FOLD   = 8'b0100_0000,
    ST_EMIT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  state_t ret_state, ret_state_next;
  logic   accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // Next state and commands
  always_comb begin
    cmd            = '0;
    state_next     = state;
    ret_state_next = ret_state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (byte_present) begin
            cmd.ins_en     = 1'b1;
            cmd.ins_src    = sha1_md_pkg::SRC_DATA;
            cmd.count_bits = 1'b1;
          end
          if (byte_present && status.fill_last) begin
            ret_state_next = end_of_message ? ST_PAD80 : ST_IDLE;
            state_next     = ST_LOAD;
          end else if (end_of_message) begin
            state_next = ST_PAD80;
          end
        end
      end
      ST_PAD80: begin
        cmd.ins_en  = 1'b1;
        cmd.ins_src = sha1_md_pkg::SRC_MARK;
        if (status.fill_last) begin
          ret_state_next = ST_PADZ;
          state_next     = ST_LOAD;
        end else begin
          state_next = ST_PADZ;
        end
      end
      ST_PADZ: begin
        if (status.fill_at_len) begin
          state_next = ST_PADLEN;
        end else begin
          cmd.ins_en  = 1'b1;
          cmd.ins_src = sha1_md_pkg::SRC_ZERO;
          if (status.fill_last) begin
            ret_state_next = ST_PADZ;
            state_next     = ST_LOAD;
          end
        end
      end
      ST_PADLEN: begin
        cmd.ins_en  = 1'b1;
        cmd.ins_src = sha1_md_pkg::SRC_LEN;
        if (status.fill_last) begin
          ret_state_next = ST_EMIT;
          state_next     = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_vars = 1'b1;
        state_next    = ST_ROUND;
      end
      ST_ROUND: begin
        cmd.round_en = 1'b1;
        if (status.round_last) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = ret_state;
      end
      ST_EMIT: begin
        // hold until the previous digest has drained
        if (!status.out_busy) begin
          cmd.emit      = 1'b1;
          cmd.clear_msg = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      ret_state <= ST_IDLE;
    end else begin
      state     <= state_next;
      ret_state <= ret_state_next;
    end
  end

endmodule

`default_nettype wire

[sv/sha1_md_dp.sv]
// ----------------------------------------------------------------------------
// SHA-1 message digest datapath
// Block buffer / schedule shift line, round registers, chaining words,
// bit length and the digest output buffer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_md_dp (
  input  wire                   clk,
  input  wire                   rst,
  input  sha1_md_pkg::cmd_t     cmd,
  output sha1_md_pkg::status_t  status,
  input  wire  [7:0]            data_byte,
  output logic                  out_valid,
  input  wire                   out_ready,
  output logic [31:0]           digest_word,
  output logic [2:0]            word_number,
  output logic                  final_word
);

  // Block buffer doubles as the 16-word schedule; word 0 is the oldest
  logic [31:0] sched [16];
  logic [31:0] va, vb, vc, vd, ve;
  logic [31:0] chain [5];
  logic [31:0] out_words [5];
  logic [5:0]  fill;
  logic [63:0] msg_bits;
  logic [6:0]  round;
  logic [2:0]  out_idx;
  logic        out_busy;

  logic [7:0]  ins_byte;
  logic [7:0]  len_byte;
  logic [31:0] w_mix;
  logic [31:0] w_new;
  logic [1:0]  stage;
  logic [31:0] f_val;
  logic [31:0] temp;
  logic        out_take;

  // Length byte for buffer slots 56..63, most significant first
  assign len_byte = msg_bits[{~fill[2:0], 3'b000} +: 8];

  // Select the byte to shift in
  always_comb begin
    unique case (cmd.ins_src)
      sha1_md_pkg::SRC_DATA: ins_byte = data_byte;
      sha1_md_pkg::SRC_MARK: ins_byte = sha1_md_pkg::PAD_MARK;
      sha1_md_pkg::SRC_ZERO: ins_byte = 8'h00;
      sha1_md_pkg::SRC_LEN:  ins_byte = len_byte;
    endcase
  end

  // Schedule expansion from fixed taps
  assign w_mix = sched[13] ^ sched[8] ^ sched[2] ^ sched[0];
  assign w_new = {w_mix[30:0], w_mix[31]};

  // Stage of the current round
  always_comb begin
    priority if (round < 7'd20) begin
      stage = 2'd0;
    end else if (round < 7'd40) begin
      stage = 2'd1;
    end else if (round < 7'd60) begin
      stage = 2'd2;
    end else begin
      stage = 2'd3;
    end
  end

  // Round function
  always_comb begin
    unique case (stage)
      2'd0:    f_val = (vb & vc) | (~vb & vd);
      2'd2:    f_val = (vb & vc) | (vb & vd) | (vc & vd);
      default: f_val = vb ^ vc ^ vd;
    endcase
  end

  assign temp = {va[26:0], va[31:27]} + f_val + ve + sched[0]
              + sha1_md_pkg::ROUND_K[stage];

  // Shift bytes in, or advance the schedule one word per round
  always_ff @(posedge clk) begin
    if (cmd.ins_en) begin
      for (int i = 0; i < 15; i++) begin
        sched[i] <= {sched[i][23:0], sched[i+1][31:24]};
      end
      sched[15] <= {sched[15][23:0], ins_byte};
    end else if (cmd.round_en) begin
      for (int i = 0; i < 15; i++) begin
        sched[i] <= sched[i+1];
      end
      sched[15] <= w_new;
    end
  end

  // Working variables
  always_ff @(posedge clk) begin
    if (cmd.load_vars) begin
      va <= chain[0];
      vb <= chain[1];
      vc <= chain[2];
      vd <= chain[3];
      ve <= chain[4];
    end else if (cmd.round_en) begin
      va <= temp;
      vb <= va;
      vc <= {vb[1:0], vb[31:2]};
      vd <= vc;
      ve <= vd;
    end
  end

  // Output buffer: capture the digest, then shift one word out per request
  assign out_take = out_busy && out_ready;

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      for (int i = 0; i < 5; i++) begin
        out_words[i] <= chain[i];
      end
    end else if (out_take) begin
      for (int i = 0; i < 4; i++) begin
        out_words[i] <= out_words[i+1];
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      fill     <= '0;
      msg_bits <= '0;
      round    <= '0;
      out_idx  <= '0;
      out_busy <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        chain[i] <= sha1_md_pkg::INIT_CHAIN[i];
      end
    end else begin
      if (cmd.ins_en) begin
        fill <= fill + 6'd1;
      end
      if (cmd.count_bits) begin
        msg_bits <= msg_bits + 64'd8;
      end
      if (cmd.load_vars) begin
        round <= '0;
      end else if (cmd.round_en) begin
        round <= round + 7'd1;
      end
      if (cmd.fold) begin
        chain[0] <= chain[0] + va;
        chain[1] <= chain[1] + vb;
        chain[2] <= chain[2] + vc;
        chain[3] <= chain[3] + vd;
        chain[4] <= chain[4] + ve;
      end
      // restart for the next message
      if (cmd.clear_msg) begin
        msg_bits <= '0;
        for (int i = 0; i < 5; i++) begin
          chain[i] <= sha1_md_pkg::INIT_CHAIN[i];
        end
      end
      if (cmd.emit) begin
        out_busy <= 1'b1;
        out_idx  <= '0;
      end else if (out_take) begin
        if (out_idx == sha1_md_pkg::WORD_LAST) begin
          out_busy <= 1'b0;
        end
        out_idx <= out_idx + 3'd1;
      end
    end
  end

  assign status.fill_last   = (fill == sha1_md_pkg::BLOCK_LAST);
  assign status.fill_at_len = (fill == sha1_md_pkg::LENGTH_AT);
  assign status.round_last  = (round == sha1_md_pkg::ROUND_LAST);
  assign status.out_busy    = out_busy;

  assign out_valid   = out_busy;
  assign digest_word = out_words[0];
  assign word_number = out_idx;
  assign final_word  = (out_idx == sha1_md_pkg::WORD_LAST);

endmodule

`default_nettype wire

[sv/sha1_message_digest.sv]
// ----------------------------------------------------------------------------
// SHA-1 message digest
// Byte-streamed SHA-1 with in-line padding; five digest words per message.
// ----------------------------------------------------------------------------
//  channel | handshake            | payload
//  --------+----------------------+--------------------------------------------
//  input   | in_valid / in_ready  | data_byte, byte_present, end_of_message
//  output  | out_valid / out_ready| digest_word, word_number, final_word
//
//  A message byte is taken whenever in_ready is high; every 64th byte
//  starts a block compression (a load, 80 rounds on the single round
//  unit, a fold) with in_ready low. An end item pads its block to the
//  end (two blocks when fewer than nine bytes remain), turns to the length
//  bytes, compresses each block and emits once the output buffer is free.
//  The digest goes to a five-word output buffer; the next message is taken
//  while it drains, and only a second digest waits for it to empty.
//  Synchronous reset restores the initial chaining words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module sha1_message_digest (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [7:0]  data_byte,
  input  wire         byte_present,
  input  wire         end_of_message,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_number,
  output logic        final_word
);

  sha1_md_pkg::cmd_t    cmd;
  sha1_md_pkg::status_t status;

  sha1_md_ctrl u_ctrl (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .byte_present   (byte_present),
    .end_of_message (end_of_message),
    .status         (status),
    .cmd            (cmd)
  );

  sha1_md_dp u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .status      (status),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_number (word_number),
    .final_word  (final_word)
  );

endmodule

`default_nettype wire

[sv/sha1_md_checker.sv]
// ----------------------------------------------------------------------------
// SHA-1 message digest port checker
// Watches the digest output sequence on the top-level ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "sha1_message_digest_macros.svh"

module sha1_md_checker (
  input wire        clk,
  input wire        rst,
  input wire        out_valid,
  input wire        out_ready,
  input wire [31:0] digest_word,
  input wire [2:0]  word_number,
  input wire        final_word
);

  // Final flag marks word four only
  `SHA1_ASSERT_IMPLY(a_final_flag, out_valid, final_word == (word_number == 3'd4), "final_word mismatch")

  // A digest starts at word zero
  `SHA1_ASSERT_IMPLY(a_first_word, $rose(out_valid), word_number == 3'd0, "digest not at word 0")

  // Words follow each other without a gap
  `SHA1_ASSERT_NEXT(a_word_step, out_valid && out_ready && !final_word, out_valid && (word_number == $past(word_number) + 3'd1), "digest word sequence broken")

  // Stalled request holds its word
  `SHA1_ASSERT_NEXT(a_hold, out_valid && !out_ready, out_valid && $stable(digest_word), "stalled digest word changed")

endmodule

bind sha1_message_digest sha1_md_checker u_checker (.*);

`default_nettype wire

[dv/sha1_message_digest_test.sv]
// ----------------------------------------------------------------------------
// SHA-1 message digest testbench
// Streams directed and random messages into the byte-wide request port and
// checks every digest word against a behavioral SHA-1 kept in the bench.
// Message lengths cluster around block and padding boundaries. Sender bursts
// and receiver stalls run independently of each other.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_message_digest_test;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [7:0]  data_byte;
  logic        byte_present;
  logic        end_of_message;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] digest_word;
  logic [2:0]  word_number;
  logic        final_word;

  sha1_message_digest i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .data_byte     (data_byte),
    .byte_present  (byte_present),
    .end_of_message(end_of_message),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .digest_word   (digest_word),
    .word_number   (word_number),
    .final_word    (final_word)
  );

  typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
  } digest_entry_t;

  // Behavioral SHA-1 with its own chaining state and a queue of digest words
  class sha1_digest_tracker;
    logic [31:0]   chain [5];
    logic [7:0]    block_bytes [64];
    int unsigned   fill;
    logic [63:0]   bit_count;
    digest_entry_t expected_words [$];
    int            errors;
    int            words_checked;
    int            messages_done;

    function new();
      errors = 0;
      words_checked = 0;
      messages_done = 0;
      start_message();
    endfunction

    function void start_message();
      for (int k = 0; k < 5; k++) chain[k] = sha1_md_pkg::INIT_CHAIN[k];
      fill = 0;
      bit_count = '0;
    endfunction

    // Expand the block and run the 80 rounds into the chaining words
    function void compress();
      logic [31:0] w [80];
      logic [31:0] a, b, c, d, e, f, t;
      int stage;
      for (int j = 0; j < 16; j++)
        w[j] = {block_bytes[4*j], block_bytes[4*j+1], block_bytes[4*j+2], block_bytes[4*j+3]};
      for (int j = 16; j < 80; j++) begin
        t = w[j-3] ^ w[j-8] ^ w[j-14] ^ w[j-16];
        w[j] = {t[30:0], t[31]};
      end
      a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3]; e = chain[4];
      for (int j = 0; j < 80; j++) begin
        stage = j / 20;
        case (stage)
          0: f = (b & c) | (~b & d);
          2: f = (b & c) | (b & d) | (c & d);
          default: f = b ^ c ^ d;
        endcase
        t = {a[26:0], a[31:27]} + f + e + w[j] + sha1_md_pkg::ROUND_K[stage];
        e = d;
        d = c;
        c = {b[1:0], b[31:2]};
        b = a;
        a = t;
      end
      chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d; chain[4] += e;
    endfunction

    // Take one accepted request; on end of message queue five digest words
    function void note_request(logic [7:0] value, logic present, logic ends);
      if (present) begin
        block_bytes[fill] = value;
        bit_count += 64'd8;
        fill++;
        if (fill == 64) begin
          compress();
          fill = 0;
        end
      end
      if (!ends) return;
      block_bytes[fill] = sha1_md_pkg::PAD_MARK;
      for (int j = fill + 1; j < 64; j++) block_bytes[j] = 8'h00;
      // no room for the length: flush and pad a second block
      if (fill >= sha1_md_pkg::LENGTH_AT) begin
        compress();
        for (int j = 0; j < 64; j++) block_bytes[j] = 8'h00;
      end
      for (int j = 0; j < 8; j++)
        block_bytes[sha1_md_pkg::LENGTH_AT + j] = bit_count[63 - 8*j -: 8];
      compress();
      for (int k = 0; k < 5; k++)
        expected_words.push_back('{chain[k], 3'(k), k == 4});
      messages_done++;
      start_message();
    endfunction

    function void check_word(logic [31:0] word, logic [2:0] index, logic last);
      digest_entry_t exp_word;
      if (expected_words.size() == 0) begin
        $error("digest word %08h (word_number %0d) with none outstanding", word, index);
        errors++;
        return;
      end
      exp_word = expected_words.pop_front();
      words_checked++;
      if (word !== exp_word.word) begin
        $error("digest_word: expected %08h, actual %08h", exp_word.word, word);
        errors++;
      end
      if (index !== exp_word.index) begin
        $error("word_number: expected %0d, actual %0d", exp_word.index, index);
        errors++;
      end
      if (last !== exp_word.last) begin
        $error("final_word: expected %0b, actual %0b", exp_word.last, last);
        errors++;
      end
    endfunction

    function int outstanding();
      return expected_words.size();
    endfunction
  endclass

  sha1_digest_tracker tracker = new();
  int requests_sent = 0;
  int burst_left = 0;

  // Clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Drive one request, wait for acceptance, then maybe idle
  task automatic send_request(input logic [7:0] value, input logic present,
                              input logic ends);
    in_valid       <= 1'b1;
    data_byte      <= value;
    byte_present   <= present;
    end_of_message <= ends;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    tracker.note_request(value, present, ends);
    if (present || ends) requests_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
      burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(30, 80)
                                                : $urandom_range(0, 12);
    end
  endtask

  // Random bytes, occasional ignored requests; end rides on the last byte or alone
  task automatic send_message(input int len, input bit joined);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 19) == 0) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      send_request(8'($urandom_range(0, 255)), 1'b1, joined && (i == len - 1));
    end
    if (!joined || len == 0) send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
  endtask

  // Receiver: check on handshake, stall in changing modes
  initial begin
    int mode;
    int mode_left;
    int tick;
    mode = 0;
    mode_left = 0;
    tick = 0;
    out_ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready)
        tracker.check_word(digest_word, word_number, final_word);
      if (mode_left == 0) begin
        mode = $urandom_range(0, 3);
        mode_left = $urandom_range(20, 120);
      end
      mode_left--;
      tick++;
      case (mode)
        0: out_ready <= 1'b1;
        1: out_ready <= tick[0];
        2: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 7) == 0);
      endcase
    end
  end

  // Stimulus
  initial begin
    int len;
    int pick;
    rst            <= 1'b1;
    in_valid       <= 1'b0;
    data_byte      <= 8'h00;
    byte_present   <= 1'b0;
    end_of_message <= 1'b0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // empty message, then ignored requests, then "abc" with end on the last byte
    send_request(8'hA5, 1'b0, 1'b1);
    send_request(8'h5A, 1'b0, 1'b0);
    send_request(8'hFF, 1'b0, 1'b0);
    send_request(8'h61, 1'b1, 1'b0);
    send_request(8'h62, 1'b1, 1'b0);
    send_request(8'h63, 1'b1, 1'b1);
    // extreme bytes, end arriving alone after data
    send_request(8'h00, 1'b1, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'hFF, 1'b1, 1'b0);
    send_request(8'h00, 1'b0, 1'b1);
    // back-to-back one-byte and empty messages
    send_request(8'hFF, 1'b1, 1'b1);
    send_request(8'h00, 1'b1, 1'b1);
    send_request(8'hFF, 1'b0, 1'b1);
    // walk a one through every bit of the byte
    for (int b = 0; b < 8; b++) send_request(8'h01 << b, 1'b1, b == 7);

    // random messages, weighted toward padding and block boundaries
    while (requests_sent < 220 || tracker.messages_done < 14) begin
      pick = $urandom_range(0, 19);
      if (pick < 14) begin
        len = $urandom_range(0, 20);
      end else if (pick < 17) begin
        case ($urandom_range(0, 7))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 65;
          6: len = 119;
          default: len = 120;
        endcase
      end else begin
        len = $urandom_range(21, 80);
      end
      send_message(len, 1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;

    // drain, then watch for stray words
    while (tracker.outstanding() != 0) @(posedge clk);
    repeat (300) @(posedge clk);

    $display("Covered %0d messages over %0d requests, including block-boundary lengths;",
             tracker.messages_done, requests_sent);
    $display("%0d digest words compared under random sender gaps and receiver stalls.",
             tracker.words_checked);
    if (tracker.errors == 0 && tracker.outstanding() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Timeout
  initial begin
    #5_000_000;
    $display("Timeout with %0d digest words outstanding", tracker.outstanding());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/sha1_md_pkg.sv
sv/sha1_md_ctrl.sv
sv/sha1_md_dp.sv
sv/sha1_message_digest.sv
sv/sha1_md_checker.sv
dv/sha1_message_digest_test.sv
